// File: src/calendar_date_adder_macros.svh
// Assertion macros for the calendar date adder.
// Used by the top level only; no dependencies.
`ifndef CALENDAR_DATE_ADDER_MACROS_SVH
`define CALENDAR_DATE_ADDER_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define CDA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent.
`define CDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cda_pkg.sv
// Shared types, constants and functions of the calendar date adder.
// No dependencies.
`default_nettype none

package cda_pkg;

	localparam int unsigned YEAR_BITS = 16;
	localparam int unsigned SUM_W     = ((YEAR_BITS > 16) ? YEAR_BITS : 16) + 1;
	localparam int unsigned TOTAL_W   = 17;
	localparam int unsigned QUOT_W    = 13;

	typedef logic [YEAR_BITS-1:0] year_t;
	typedef logic [3:0]           month_t;
	typedef logic [4:0]           day_t;
	typedef logic [15:0]          amount_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [TOTAL_W-1:0]   total_t;
	typedef logic [QUOT_W-1:0]    quot_t;

	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_DAYS   = 2'd1,
		FN_MONTHS = 2'd2,
		FN_YEARS  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LOAD = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam year_t  YEAR_MAX   = '1;
	localparam year_t  RESET_YEAR = year_t'(2000);
	localparam month_t MONTH_JAN  = 4'd1;
	localparam month_t MONTH_FEB  = 4'd2;
	localparam month_t MONTH_MAR  = 4'd3;
	localparam month_t MONTH_DEC  = 4'd12;
	localparam day_t   DAY_FIRST  = 5'd1;
	localparam day_t   DAY_LEAP   = 5'd29;

	// x / 3 == (x * DIV3_MUL) >> DIV3_SHIFT for any 16-bit x
	localparam logic [31:0] DIV3_MUL   = 32'd43691;
	localparam int unsigned DIV3_SHIFT = 17;

	// multiplicative inverse of 25 modulo 2^64, by Newton iteration
	function automatic logic [63:0] inv25_calc();
		logic [63:0] x;
		x = 64'd25;
		for (int i = 0; i < 5; i++) begin
			x = x * (64'd2 - 64'd25 * x);
		end
		return x;
	endfunction

	localparam year_t INV25     = year_t'(inv25_calc());
	localparam year_t DIV25_LIM = YEAR_MAX / 25;

	function automatic day_t month_len(input logic leap, input month_t m);
		day_t len;
		case (m) inside
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	typedef struct packed {
		day_t    len;
		logic    fits;
		day_t    d_sum;
		amount_t n_rem;
	} step_t;

endpackage

`default_nettype wire

// File: src/cda_in_if.sv
// Request channel of the calendar date adder: operation and load date.
// Depends on cda_pkg.
`default_nettype none

interface cda_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	cda_pkg::amount_t  amount;
	logic [15:0]       load_year;
	cda_pkg::month_t   load_month;
	cda_pkg::day_t     load_day;

	modport source (output valid, func, amount, load_year, load_month, load_day,
		input ready);
	modport sink (input valid, func, amount, load_year, load_month, load_day,
		output ready);
endinterface

`default_nettype wire

// File: src/cda_out_if.sv
// Response channel of the calendar date adder: date held and status.
// Depends on cda_pkg.
`default_nettype none

interface cda_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       year;
	cda_pkg::month_t   month;
	cda_pkg::day_t     day;
	logic [1:0]        status;

	modport source (output valid, year, month, day, status, input ready);
	modport sink (input valid, year, month, day, status, output ready);
endinterface

`default_nettype wire

// File: src/cda_leap.sv
// Gregorian leap-year test on one year.
// Divisibility by 25 through multiplication by its modular inverse. Depends on cda_pkg.
`default_nettype none

module cda_leap (
	input  cda_pkg::year_t year,
	output logic           leap
);

	cda_pkg::year_t prod;
	logic           div25;

	assign prod  = cda_pkg::year_t'(year * cda_pkg::INV25);
	assign div25 = (prod <= cda_pkg::DIV25_LIM);

	// century years only when divisible by 400 (i.e. by 16 once divisible by 25)
	assign leap = (year[1:0] == 2'd0) && !(div25 && (year[3:0] != 4'd0));

endmodule

`default_nettype wire

// File: src/cda_step.sv
// Month-step unit: month length, room left in the month and the remaining day count.
// Shared by the add-days walk and the load check. Depends on cda_pkg.
`default_nettype none

module cda_step (
	input  cda_pkg::month_t  m,
	input  cda_pkg::day_t    d,
	input  cda_pkg::amount_t n,
	input  logic             leap,
	output cda_pkg::step_t   res
);

	cda_pkg::day_t len;
	cda_pkg::day_t left;

	assign len  = cda_pkg::month_len(leap, m);
	// a day past month end counts as the last day
	assign left = (d <= len) ? cda_pkg::day_t'(len - d) : 5'd0;

	assign res.len   = len;
	assign res.fits  = (n <= cda_pkg::amount_t'(left));
	assign res.d_sum = cda_pkg::day_t'(d + n[4:0]);
	assign res.n_rem = cda_pkg::amount_t'(n - cda_pkg::amount_t'(left) - 16'd1);

endmodule

`default_nettype wire

// File: src/calendar_date_adder.sv
// Calendar date adder: holds a Gregorian date (reset 2000-01-01) and applies one
// operation per request transaction (load, add days, add months, add years), returning
// the date held and a status in one response transaction. One request is processed at a
// time and the request channel is not ready until the result sits in the output
// register. Load goes through S_LEAP and S_LCHK, add months through S_MDIV and
// S_MADD, add years through S_LEAP and S_YFIX, each then S_DONE. Add days walks the
// shared month-step unit one month per cycle in S_WALK, with a fresh leap test in
// S_LEAP at each year boundary crossed. S_DONE waits while a previous response
// still sits unaccepted in the output register.
// Depends on cda_pkg, cda_in_if, cda_out_if, cda_leap, cda_step and the macro header.
`default_nettype none

`include "calendar_date_adder_macros.svh"

module calendar_date_adder (
	input  logic       clk,
	input  logic       arst_n,
	cda_in_if.sink     req,
	cda_out_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEAP,
		S_LCHK,
		S_WALK,
		S_MDIV,
		S_MADD,
		S_YFIX,
		S_DONE
	} state_t;

	state_t              state_q;
	cda_pkg::func_t      func_q;
	cda_pkg::amount_t    n_q;
	cda_pkg::year_t      wy_q;
	cda_pkg::month_t     wm_q;
	cda_pkg::day_t       wd_q;
	logic                leap_q;
	logic                bad_q;
	logic                ovf_q;
	cda_pkg::total_t     tot_q;
	cda_pkg::quot_t      quo_q;
	cda_pkg::year_t      cur_y_q;
	cda_pkg::month_t     cur_m_q;
	cda_pkg::day_t       cur_d_q;
	cda_pkg::status_t    st_q;
	logic                rsp_valid_q;
	logic [15:0]         rsp_year_q;
	cda_pkg::month_t     rsp_month_q;
	cda_pkg::day_t       rsp_day_q;
	logic [1:0]          rsp_status_q;

	logic                leap_y;
	cda_pkg::step_t      step;
	cda_pkg::sum_t       add_b;
	cda_pkg::sum_t       yr_sum;
	logic                yr_ovf;
	cda_pkg::total_t     tot_next;
	logic [31:0]         div_prod;
	cda_pkg::quot_t      quo_next;
	cda_pkg::total_t     quo12;
	cda_pkg::total_t     rem;
	logic                lyear_bad;
	logic                lmonth_bad;

	cda_leap u_leap (
		.year (wy_q),
		.leap (leap_y)
	);

	cda_step u_step (
		.m    (wm_q),
		.d    (wd_q),
		.n    (n_q),
		.leap (leap_q),
		.res  (step)
	);

	// one year adder: amount on acceptance, quotient of the month split later
	assign add_b  = (state_q == S_IDLE) ? cda_pkg::sum_t'(req.amount)
		: cda_pkg::sum_t'(quo_q);
	assign yr_sum = cda_pkg::sum_t'(cur_y_q) + add_b;
	assign yr_ovf = (yr_sum > cda_pkg::sum_t'(cda_pkg::YEAR_MAX));

	assign tot_next = cda_pkg::total_t'(cur_m_q) - cda_pkg::total_t'(1)
		+ cda_pkg::total_t'(req.amount);

	// divide by 12: shift by 2, then multiply by the reciprocal of 3
	assign div_prod = 32'(tot_q[cda_pkg::TOTAL_W-1:2]) * cda_pkg::DIV3_MUL;
	assign quo_next = cda_pkg::quot_t'(div_prod >> cda_pkg::DIV3_SHIFT);
	assign quo12    = (cda_pkg::total_t'(quo_q) << 3) + (cda_pkg::total_t'(quo_q) << 2);
	assign rem      = cda_pkg::total_t'(tot_q - quo12);

	assign lyear_bad  = (req.load_year == 16'd0)
		|| (cda_pkg::sum_t'(req.load_year) > cda_pkg::sum_t'(cda_pkg::YEAR_MAX));
	assign lmonth_bad = (req.load_month == 4'd0) || (req.load_month > cda_pkg::MONTH_DEC);

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.year   = rsp_year_q;
	assign rsp.month  = rsp_month_q;
	assign rsp.day    = rsp_day_q;
	assign rsp.status = rsp_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			func_q       <= cda_pkg::FN_LOAD;
			n_q          <= '0;
			wy_q         <= cda_pkg::RESET_YEAR;
			wm_q         <= cda_pkg::MONTH_JAN;
			wd_q         <= cda_pkg::DAY_FIRST;
			leap_q       <= 1'b0;
			bad_q        <= 1'b0;
			ovf_q        <= 1'b0;
			tot_q        <= '0;
			quo_q        <= '0;
			cur_y_q      <= cda_pkg::RESET_YEAR;
			cur_m_q      <= cda_pkg::MONTH_JAN;
			cur_d_q      <= cda_pkg::DAY_FIRST;
			st_q         <= cda_pkg::ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_year_q   <= '0;
			rsp_month_q  <= '0;
			rsp_day_q    <= '0;
			rsp_status_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						func_q <= cda_pkg::func_t'(req.func);
						n_q    <= req.amount;
						tot_q  <= tot_next;
						unique case (cda_pkg::func_t'(req.func))
							cda_pkg::FN_LOAD: begin
								wy_q    <= cda_pkg::year_t'(req.load_year);
								wm_q    <= req.load_month;
								wd_q    <= req.load_day;
								bad_q   <= lyear_bad || lmonth_bad;
								ovf_q   <= 1'b0;
								state_q <= S_LEAP;
							end
							cda_pkg::FN_DAYS: begin
								wy_q    <= cur_y_q;
								wm_q    <= cur_m_q;
								wd_q    <= cur_d_q;
								bad_q   <= 1'b0;
								ovf_q   <= 1'b0;
								state_q <= S_LEAP;
							end
							cda_pkg::FN_MONTHS: begin
								wy_q    <= cur_y_q;
								wm_q    <= cur_m_q;
								wd_q    <= cur_d_q;
								bad_q   <= 1'b0;
								ovf_q   <= 1'b0;
								state_q <= S_MDIV;
							end
							cda_pkg::FN_YEARS: begin
								wy_q    <= cda_pkg::year_t'(yr_sum);
								wm_q    <= cur_m_q;
								wd_q    <= cur_d_q;
								bad_q   <= 1'b0;
								ovf_q   <= yr_ovf;
								state_q <= S_LEAP;
							end
						endcase
					end
				end
				S_LEAP: begin
					leap_q <= leap_y;
					unique case (func_q)
						cda_pkg::FN_LOAD:                     state_q <= S_LCHK;
						cda_pkg::FN_DAYS:                     state_q <= S_WALK;
						cda_pkg::FN_MONTHS, cda_pkg::FN_YEARS: state_q <= S_YFIX;
					endcase
				end
				S_LCHK: begin
					if (bad_q || (wd_q == 5'd0) || (wd_q > step.len)) begin
						st_q <= cda_pkg::ST_BAD_LOAD;
					end else begin
						cur_y_q <= wy_q;
						cur_m_q <= wm_q;
						cur_d_q <= wd_q;
						st_q    <= cda_pkg::ST_OK;
					end
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (step.fits) begin
						cur_y_q <= wy_q;
						cur_m_q <= wm_q;
						cur_d_q <= step.d_sum;
						st_q    <= cda_pkg::ST_OK;
						state_q <= S_DONE;
					end else begin
						n_q  <= step.n_rem;
						wd_q <= cda_pkg::DAY_FIRST;
						if (wm_q >= cda_pkg::MONTH_DEC) begin
							wm_q <= cda_pkg::MONTH_JAN;
							if (wy_q == cda_pkg::YEAR_MAX) begin
								st_q    <= cda_pkg::ST_OVERFLOW;
								state_q <= S_DONE;
							end else begin
								wy_q    <= cda_pkg::year_t'(wy_q + cda_pkg::year_t'(1));
								state_q <= S_LEAP;
							end
						end else begin
							wm_q <= cda_pkg::month_t'(wm_q + 4'd1);
						end
					end
				end
				S_MDIV: begin
					quo_q   <= quo_next;
					state_q <= S_MADD;
				end
				S_MADD: begin
					if (yr_ovf) begin
						st_q <= cda_pkg::ST_OVERFLOW;
					end else begin
						cur_y_q <= cda_pkg::year_t'(yr_sum);
						cur_m_q <= cda_pkg::month_t'(rem[3:0] + 4'd1);
						st_q    <= cda_pkg::ST_OK;
					end
					state_q <= S_DONE;
				end
				S_YFIX: begin
					if (ovf_q) begin
						st_q <= cda_pkg::ST_OVERFLOW;
					end else begin
						cur_y_q <= wy_q;
						if ((cur_m_q == cda_pkg::MONTH_FEB) && (cur_d_q == cda_pkg::DAY_LEAP)
							&& !leap_q) begin
							cur_m_q <= cda_pkg::MONTH_MAR;
							cur_d_q <= cda_pkg::DAY_FIRST;
						end
						st_q <= cda_pkg::ST_OK;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_year_q   <= 16'(cur_y_q);
						rsp_month_q  <= cur_m_q;
						rsp_day_q    <= cur_d_q;
						rsp_status_q <= 2'(st_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CDA_ASSERT_ALWAYS(a_month_range, clk, arst_n, (cur_m_q >= cda_pkg::MONTH_JAN) && (cur_m_q <= cda_pkg::MONTH_DEC), "held month out of range")
	`CDA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "request accepted while busy")
	`CDA_ASSERT_NEXT(a_idle_date_stable, clk, arst_n, state_q == S_IDLE, $stable(cur_y_q) && $stable(cur_m_q) && $stable(cur_d_q), "date changed while idle")

endmodule

`default_nettype wire
